// ===== sv/cell_group_pec_check_min_max_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cell group check and min / max tracker
// Both macros check a property on the rising clock edge and are switched off
// while reset is high.
// ---------------------------------------------------------------------------
`ifndef CELL_GROUP_PEC_CHECK_MIN_MAX_MACROS_SVH
`define CELL_GROUP_PEC_CHECK_MIN_MAX_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define CGPMM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cell group tracker: assertion failed");

// Next-cycle implication
`define CGPMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cell group tracker: assertion failed");

`else

`define CGPMM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CGPMM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/cgpmm_pkg.sv =====
// ---------------------------------------------------------------------------
// Cell group tracker package
// Constants, types and elaboration-time CRC tables for the cell group
// check and min / max / total tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cgpmm_pkg;

   // Chain and frame geometry
   localparam int NUM_MONITORS = 6;
   localparam int DATA_BYTES   = 6;
   localparam int DATA_BITS    = 8 * DATA_BYTES;
   localparam int CELLS_PER_GROUP = 3;

   // 15-bit CRC (bytewise form, result shifted left by one)
   localparam logic [15:0] CRC_POLY = 16'h4599;
   localparam logic [15:0] CRC_TOP  = 16'h4000;
   localparam logic [15:0] CRC_SEED = 16'd16;

   // Cell counts
   localparam logic [3:0] CELLS_MAX      = 4'd12;
   localparam logic [3:0] CELLS_EVEN_RST = 4'd12;
   localparam logic [3:0] CELLS_ODD_RST  = 4'd9;

   // Total saturates at the top of its 22-bit range
   localparam logic [21:0] SUM_MAX = 22'h3F_FFFF;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_CELLS_EVEN = 2'd0,
      CSR_CELLS_ODD  = 2'd1
   } csr_index_type;

   // One extreme (code and where it sits)
   typedef struct packed {
      logic [15:0] code;
      logic [2:0]  monitor;
      logic [3:0]  cell_pos;
   } extreme_type;

   // Scan trackers
   typedef struct packed {
      extreme_type low;
      extreme_type high;
      logic [21:0] total;
   } tracker_type;

   localparam tracker_type TRACKER_CLEAR = '{
      low:   '{code: 16'hFFFF, monitor: 3'd0, cell_pos: 4'd0},
      high:  '{code: 16'h0000, monitor: 3'd0, cell_pos: 4'd0},
      total: 22'd0
   };

   typedef logic [DATA_BITS-1:0][15:0] crc_cols_type;

   // One entry of the bytewise CRC table
   function automatic logic [15:0] crc_table_entry(logic [7:0] idx);
      logic [15:0] r;
      r = {1'b0, idx, 7'b0};
      for (int b = 0; b < 8; b++) begin
         if ((r & CRC_TOP) != 16'd0) begin
            r = (r << 1) ^ CRC_POLY;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

   // Bytewise CRC over the data bytes, byte zero first
   function automatic logic [15:0] crc_serial(logic [DATA_BITS-1:0] bytes);
      logic [15:0] r;
      logic [7:0]  a;
      r = CRC_SEED;
      for (int i = 0; i < DATA_BYTES; i++) begin
         a = r[14:7] ^ bytes[8*i +: 8];
         r = (r << 8) ^ crc_table_entry(a);
      end
      return r << 1;
   endfunction

   // Contribution of each data bit; the CRC is linear over GF(2)
   function automatic crc_cols_type crc_columns();
      crc_cols_type cols;
      for (int i = 0; i < DATA_BITS; i++) begin
         cols[i] = crc_serial(DATA_BITS'(1) << i) ^ crc_serial('0);
      end
      return cols;
   endfunction

   localparam logic [15:0]  CRC_ZERO = crc_serial('0);
   localparam crc_cols_type CRC_COLS = crc_columns();

endpackage

// ===== sv/cell_group_pec_check_min_max.sv =====
// An accepted frame passes the input register and then the result register on its
// way to rsp_tdata; a full result register waiting on rsp_tready holds it in between.
// Throughput: one frame per cycle while rsp_tready keeps up; the input register and
// the result register let a new frame in while a finished result waits on rsp_tready.
// The tracker update (three cascaded strict compares per extreme and one clamped sum)
// sits between those two registers. csr_ready is always high.
// Reset: trackers clear (lowest code all ones), cell counts go to 12 and 9.
// ---------------------------------------------------------------------------
// Cell group CRC check and min / max / total tracker
// Checks the 15-bit CRC of each six-byte register group, unpacks three cell
// codes and tracks the scan total, minimum and maximum with their locations.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cell_group_pec_check_min_max_macros.svh"

module cell_group_pec_check_min_max #(
   parameter int NUM_MONITORS = cgpmm_pkg::NUM_MONITORS
) (
   input  logic        clock,
   input  logic        reset,
   // input frames
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // group_bytes[47:0], check_bytes[63:48]
   input  logic [5:0]  req_tuser,  // monitor_index[2:0], group_index[4:3], scan_start[5]
   input  logic        req_tlast,  // scan_end
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // lowest_code[15:0], lowest_monitor[18:16],
                                   // lowest_cell[22:19], highest_code[38:23],
                                   // highest_monitor[41:39], highest_cell[45:42],
                                   // total_code[67:46], zero[71:68]
   output logic        rsp_tuser,  // crc_ok
   output logic        rsp_tlast,  // scan_done
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   // Configuration registers
   logic [3:0] cells_even_ff;
   logic [3:0] cells_odd_ff;

   // Input register
   logic        s1_valid_ff;
   logic [47:0] s1_bytes_ff;
   logic [15:0] s1_check_ff;
   logic [2:0]  s1_mon_ff;
   logic [1:0]  s1_grp_ff;
   logic        s1_start_ff;
   logic        s1_end_ff;

   // Trackers and result register
   cgpmm_pkg::tracker_type tracker_ff;
   cgpmm_pkg::tracker_type tracker_in;
   logic                   rsp_valid_ff;
   cgpmm_pkg::tracker_type rsp_result_ff;
   logic                   rsp_crc_ok_ff;
   logic                   rsp_last_ff;

   logic        s2_take;
   logic        advance;
   logic        crc_ok_in;
   logic [15:0] crc_calc;

   // Handshakes
   assign s2_take    = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && s2_take;
   assign req_tready = !s1_valid_ff || s2_take;
   assign csr_ready  = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_even_ff <= cgpmm_pkg::CELLS_EVEN_RST;
         cells_odd_ff  <= cgpmm_pkg::CELLS_ODD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            cgpmm_pkg::CSR_CELLS_EVEN: begin
               cells_even_ff <= csr_data;
            end
            cgpmm_pkg::CSR_CELLS_ODD: begin
               cells_odd_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_bytes_ff <= req_tdata[47:0];
         s1_check_ff <= req_tdata[63:48];
         s1_mon_ff   <= req_tuser[2:0];
         s1_grp_ff   <= req_tuser[4:3];
         s1_start_ff <= req_tuser[5];
         s1_end_ff   <= req_tlast;
      end
   end

   // CRC: XOR of per-bit columns on top of the all-zero frame value
   always_comb begin
      crc_calc = cgpmm_pkg::CRC_ZERO;
      for (int i = 0; i < cgpmm_pkg::DATA_BITS; i++) begin
         if (s1_bytes_ff[i]) begin
            crc_calc = crc_calc ^ cgpmm_pkg::CRC_COLS[i];
         end
      end
   end

   assign crc_ok_in = (crc_calc == s1_check_ff);

   // Tracker update for the three cells of the frame
   always_comb begin
      cgpmm_pkg::tracker_type base;
      logic [3:0]  count;
      logic [3:0]  cell_base;
      logic [3:0]  cell_pos;
      logic [15:0] code;
      logic [23:0] sum_wide;
      logic        mon_ok;

      base = s1_start_ff ? cgpmm_pkg::TRACKER_CLEAR : tracker_ff;
      count = s1_mon_ff[0] ? cells_odd_ff : cells_even_ff;
      if (count > cgpmm_pkg::CELLS_MAX) begin
         count = cgpmm_pkg::CELLS_MAX;
      end
      mon_ok    = (5'(s1_mon_ff) < 5'(NUM_MONITORS));
      cell_base = {1'b0, s1_grp_ff, 1'b0} + {2'b00, s1_grp_ff};

      tracker_in = base;
      sum_wide   = {2'b00, base.total};
      for (int k = 0; k < cgpmm_pkg::CELLS_PER_GROUP; k++) begin
         cell_pos = cell_base + 4'(k);
         code     = s1_bytes_ff[16*k +: 16];
         if (mon_ok && (cell_pos < count)) begin
            sum_wide = sum_wide + {8'b0, code};
            if (code < tracker_in.low.code) begin
               tracker_in.low.code     = code;
               tracker_in.low.monitor  = s1_mon_ff;
               tracker_in.low.cell_pos = cell_pos;
            end
            if (code > tracker_in.high.code) begin
               tracker_in.high.code     = code;
               tracker_in.high.monitor  = s1_mon_ff;
               tracker_in.high.cell_pos = cell_pos;
            end
         end
      end
      // Codes are non-negative, so one clamp equals clamping after each add
      if (sum_wide > {2'b00, cgpmm_pkg::SUM_MAX}) begin
         tracker_in.total = cgpmm_pkg::SUM_MAX;
      end else begin
         tracker_in.total = sum_wide[21:0];
      end
   end

   // Trackers move only when a frame passes into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         tracker_ff <= cgpmm_pkg::TRACKER_CLEAR;
      end else if (advance) begin
         tracker_ff <= tracker_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_take) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= tracker_in;
         rsp_crc_ok_ff <= crc_ok_in;
         rsp_last_ff   <= s1_end_ff;
      end
   end

   // Result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_crc_ok_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_result_ff.total,
                        rsp_result_ff.high.cell_pos,
                        rsp_result_ff.high.monitor,
                        rsp_result_ff.high.code,
                        rsp_result_ff.low.cell_pos,
                        rsp_result_ff.low.monitor,
                        rsp_result_ff.low.code};

   // Assertions
   `CGPMM_ASSERT_IMPLIES(a_min_le_max, clock, reset, 1'b1,
      (tracker_ff.low.code <= tracker_ff.high.code) ||
      ((tracker_ff.low.code == 16'hFFFF) && (tracker_ff.high.code == 16'h0000)))
   `CGPMM_ASSERT_IMPLIES(a_cell_range, clock, reset, 1'b1,
      (tracker_ff.low.cell_pos <= 4'd11) && (tracker_ff.high.cell_pos <= 4'd11))
   `CGPMM_ASSERT_NEXT(a_track_hold, clock, reset, !advance, $stable(tracker_ff))

endmodule

// ===== verif/cell_group_pec_check_min_max_tb.sv =====
// ---------------------------------------------------------------------------
// Testbench for the cell group CRC check and min / max / total tracker
// Sends register-group frames with random gaps and takes results with random
// stalls. A local tracker model predicts each result: CRC flag, scan end,
// lowest and highest cell with location, and the saturating total. Each
// result is checked field by field. Covers the cell-count registers, out of
// range monitors, bad check bytes, equal codes, total saturation and a long
// receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cell_group_pec_check_min_max_tb;
   import cgpmm_pkg::*;

   localparam int          CLK_PERIOD      = 12;
   localparam int          CYCLE_LIMIT     = 200000;
   localparam int          RANDOM_FRAMES   = 600;
   localparam int          HOLD_OFF_CYCLES = 80;
   localparam logic [14:0] PEC_POLY        = 15'h4599;
   localparam logic [14:0] PEC_SEED        = 15'd16;

   // One register-group frame as it enters the block
   typedef struct packed {
      logic [47:0] bytes;
      logic [15:0] check;
      logic [2:0]  monitor;
      logic [1:0]  group;
      logic        scan_start;
      logic        scan_end;
   } frame_t;

   // One predicted result
   typedef struct packed {
      logic        crc_ok;
      logic        scan_done;
      tracker_type trk;
   } scan_result_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [5:0]  req_tuser  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [3:0]  csr_data   = '0;

   // Tracker model state and its copy of the cell-count registers
   logic [3:0]   cells_even_cfg = CELLS_EVEN_RST;
   logic [3:0]   cells_odd_cfg  = CELLS_ODD_RST;
   tracker_type  tracked        = TRACKER_CLEAR;
   scan_result_t expected_results [$];

   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          hold_cycles    = 0;
   bit          no_gaps        = 1'b0;
   logic [15:0] scan_base      = 16'd32000;

   cell_group_pec_check_min_max uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Bit-serial 15-bit PEC, byte zero first, MSB first within a byte
   function automatic logic [15:0] frame_pec(logic [47:0] bytes);
      logic [14:0] rem;
      logic        fb;
      rem = PEC_SEED;
      for (int b = 0; b < 6; b++) begin
         for (int i = 7; i >= 0; i--) begin
            fb  = bytes[8*b+i] ^ rem[14];
            rem = {rem[13:0], 1'b0} ^ (fb ? PEC_POLY : 15'd0);
         end
      end
      return {rem, 1'b0};
   endfunction

   // Advance the trackers by one frame and return what the block should show
   function automatic scan_result_t predict_frame(frame_t f);
      scan_result_t r;
      logic [3:0]   populated;
      logic [3:0]   position;
      logic [15:0]  code;
      logic [22:0]  total_next;
      if (f.scan_start) begin
         tracked = TRACKER_CLEAR;
      end
      populated = f.monitor[0] ? cells_odd_cfg : cells_even_cfg;
      if (populated > CELLS_MAX) begin
         populated = CELLS_MAX;
      end
      if (f.monitor < NUM_MONITORS) begin
         for (int k = 0; k < 3; k++) begin
            position = 4'(3 * f.group + k);
            if (position < populated) begin
               code       = f.bytes[16*k +: 16];
               total_next = tracked.total + code;
               if (total_next > SUM_MAX) begin
                  total_next = SUM_MAX;
               end
               tracked.total = total_next[21:0];
               // strict compares keep the first location of a tie
               if (code < tracked.low.code) begin
                  tracked.low.code     = code;
                  tracked.low.monitor  = f.monitor;
                  tracked.low.cell_pos = position;
               end
               if (code > tracked.high.code) begin
                  tracked.high.code     = code;
                  tracked.high.monitor  = f.monitor;
                  tracked.high.cell_pos = position;
               end
            end
         end
      end
      r.crc_ok    = (frame_pec(f.bytes) == f.check);
      r.scan_done = f.scan_end;
      r.trk       = tracked;
      return r;
   endfunction

   function automatic frame_t make_frame(logic [47:0] bytes, logic [2:0] mon, logic [1:0] grp,
                                         bit start, bit last, bit good);
      frame_t f;
      f.bytes      = bytes;
      f.check      = frame_pec(bytes);
      f.monitor    = mon;
      f.group      = grp;
      f.scan_start = start;
      f.scan_end   = last;
      if (!good) begin
         f.check = f.check ^ 16'($urandom_range(1, 16'hFFFF));
      end
      return f;
   endfunction

   // Mostly codes clustered around the scan base so ties and near-ties show up
   function automatic logic [15:0] random_code();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom);
         default: return scan_base + 16'($urandom_range(0, 31)) - 16'd16;
      endcase
   endfunction

   function automatic logic [47:0] random_group_bytes();
      return {random_code(), random_code(), random_code()};
   endfunction

   function automatic frame_t noise_frame();
      frame_t f;
      f.bytes      = {16'($urandom), 32'($urandom)};
      f.check      = 16'($urandom);
      f.monitor    = 3'($urandom_range(0, 7));
      f.group      = 2'($urandom_range(0, 3));
      f.scan_start = ($urandom_range(0, 3) == 0);
      f.scan_end   = ($urandom_range(0, 3) == 0);
      return f;
   endfunction

   // Offer one frame after a random gap; record the prediction on acceptance
   task automatic send_frame(frame_t f);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {f.check, f.bytes};
      req_tuser  <= {f.scan_start, f.group, f.monitor};
      req_tlast  <= f.scan_end;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_frame(f));
   endtask

   // Stop offering and let every outstanding result drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both cell-count registers back to back; only call when idle
   task automatic set_cell_counts(logic [3:0] even_cells, logic [3:0] odd_cells);
      csr_valid <= 1'b1;
      csr_index <= CSR_CELLS_EVEN;
      csr_data  <= even_cells;
      do @(posedge clock); while (!csr_ready);
      cells_even_cfg = even_cells;
      csr_index <= CSR_CELLS_ODD;
      csr_data  <= odd_cells;
      do @(posedge clock); while (!csr_ready);
      cells_odd_cfg = odd_cells;
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Edge cases under the reset cell counts
   task automatic test_directed();
      logic [15:0] c;
      frame_t      f;
      c = 16'($urandom_range(1000, 60000));
      send_frame(make_frame(48'h0, 3'd0, 2'd0, 1, 0, 1));
      send_frame(make_frame({3{16'hFFFF}}, 3'd0, 2'd1, 0, 0, 1));
      // bad check bytes: cells still count
      send_frame(make_frame(random_group_bytes(), 3'd1, 2'd2, 0, 0, 0));
      // group D on an odd monitor lies beyond its nine cells
      send_frame(make_frame(random_group_bytes(), 3'd1, 2'd3, 0, 0, 1));
      send_frame(make_frame(random_group_bytes(), 3'd0, 2'd3, 0, 0, 1));
      // monitors past the chain end
      send_frame(make_frame({3{16'hFFFF}}, 3'd6, 2'd0, 0, 0, 1));
      send_frame(make_frame(48'h0, 3'd7, 2'd1, 0, 0, 0));
      // equal codes everywhere: first location wins both extremes
      send_frame(make_frame({c, c, c}, 3'd2, 2'd0, 1, 0, 1));
      send_frame(make_frame({c, c, c}, 3'd3, 2'd1, 0, 0, 1));
      send_frame(make_frame({c, c, c}, 3'd5, 2'd2, 0, 1, 1));
      // empty scan keeps the cleared trackers
      send_frame(make_frame(random_group_bytes(), 3'd7, 2'd0, 1, 1, 1));
      send_frame(make_frame(random_group_bytes(), 3'd4, 2'd1, 1, 1, 1));
      send_frame(make_frame(random_group_bytes(), 3'd2, 2'd2, 0, 0, 1));
      send_frame(make_frame(random_group_bytes(), 3'd3, 2'd3, 1, 0, 1));
      f = make_frame(48'hFFFF_FFFF_FFFF, 3'd4, 2'd2, 0, 0, 1);
      f.check = 16'hFFFF;
      send_frame(f);
      f = make_frame(48'h0000_0000_0001, 3'd5, 2'd0, 0, 1, 1);
      f.check = 16'h0000;
      send_frame(f);
      wait_idle();
   endtask

   // Sweep the cell counts, extremes and values above twelve included
   task automatic test_cell_counts();
      for (int s = 0; s < 6; s++) begin
         case (s)
            0: set_cell_counts(4'd0, 4'd0);
            1: set_cell_counts(4'd12, 4'd12);
            2: set_cell_counts(4'd15, 4'd13);
            3: set_cell_counts(4'd1, 4'd15);
            4: set_cell_counts(4'd7, 4'd3);
            default: set_cell_counts(CELLS_EVEN_RST, CELLS_ODD_RST);
         endcase
         for (int i = 0; i < 32; i++) begin
            send_frame(make_frame(random_group_bytes(), 3'(i % 8), 2'(i / 8), i == 0, i == 31,
                                  $urandom_range(0, 7) != 0));
         end
         wait_idle();
      end
   endtask

   // Full-scale codes on every cell drive the total into saturation
   task automatic test_total_saturation();
      set_cell_counts(4'd12, 4'd12);
      for (int i = 0; i < 4 * NUM_MONITORS; i++) begin
         send_frame(make_frame({3{16'hFFFF}}, 3'(i / 4), 2'(i % 4), i == 0,
                               i == 4 * NUM_MONITORS - 1, 1));
      end
      wait_idle();
      set_cell_counts(CELLS_EVEN_RST, CELLS_ODD_RST);
   endtask

   // Receiver holds off while frames keep coming, so the input stalls
   task automatic test_backpressure();
      hold_cycles = HOLD_OFF_CYCLES;
      no_gaps     = 1'b1;
      for (int i = 0; i < 4 * NUM_MONITORS; i++) begin
         send_frame(make_frame(random_group_bytes(), 3'(i / 4), 2'(i % 4), i == 0,
                               i == 4 * NUM_MONITORS - 1, 1));
      end
      no_gaps = 1'b0;
      wait_idle();
   endtask

   // Mostly complete scans, some partial scans, some noise
   task automatic test_random_scans();
      int sent;
      int scans;
      int kind;
      int n;
      sent  = 0;
      scans = 0;
      while (sent < RANDOM_FRAMES) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if (scans % 8 == 7) begin
            wait_idle();
            set_cell_counts(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end
         scan_base = 16'($urandom_range(100, 65400));
         kind      = $urandom_range(0, 9);
         if (kind <= 6) begin
            for (int m = 0; m < NUM_MONITORS; m++) begin
               for (int g = 0; g < 4; g++) begin
                  send_frame(make_frame(random_group_bytes(), 3'(m), 2'(g), m == 0 && g == 0,
                                        m == NUM_MONITORS - 1 && g == 3,
                                        $urandom_range(0, 9) != 0));
                  sent++;
               end
            end
         end else if (kind == 7) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
               send_frame(make_frame(random_group_bytes(), 3'($urandom_range(0, 7)),
                                     2'($urandom_range(0, 3)), i == 0, i == n - 1, 1));
               sent++;
            end
         end else begin
            for (int i = 0; i < 5; i++) begin
               send_frame(noise_frame());
               sent++;
            end
         end
         scans++;
      end
      no_gaps = 1'b0;
   endtask

   // Result side: random stalls, or one long hold-off when requested
   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      scan_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual tdata %h", $time,
                     rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("crc_ok", want.crc_ok, rsp_tuser);
            check_field("scan_done", want.scan_done, rsp_tlast);
            check_field("lowest_code", want.trk.low.code, rsp_tdata[15:0]);
            check_field("lowest_monitor", want.trk.low.monitor, rsp_tdata[18:16]);
            check_field("lowest_cell", want.trk.low.cell_pos, rsp_tdata[22:19]);
            check_field("highest_code", want.trk.high.code, rsp_tdata[38:23]);
            check_field("highest_monitor", want.trk.high.monitor, rsp_tdata[41:39]);
            check_field("highest_cell", want.trk.high.cell_pos, rsp_tdata[45:42]);
            check_field("total_code", want.trk.total, rsp_tdata[67:46]);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_cell_counts();
      test_total_saturation();
      test_backpressure();
      test_random_scans();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== cell_group_pec_check_min_max.f =====
+incdir+sv
sv/cgpmm_pkg.sv
sv/cell_group_pec_check_min_max.sv
verif/cell_group_pec_check_min_max_tb.sv
